[hdl/indexed_stack_engine_defines.svh]
// ----------------------------------------------------------------------------
// indexed_stack_engine_defines
// Assertion macros used by the stack engine controller RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_STACK_ENGINE_DEFINES_SVH
`define INDEXED_STACK_ENGINE_DEFINES_SVH

// clocked check, masked while reset is high
`define ISE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ISE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ise_pkg.sv]
// ----------------------------------------------------------------------------
// ise_pkg
// Types, codes and sizes shared by the stack engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ise_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_W-1:0] OP_CHANGE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPOS    = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } out_word_t;

  // result handed from the controller to the output register
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

  // one cycle of RAM traffic
  typedef struct packed {
    logic              we;
    addr_t             waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    addr_t             raddr;
  } ram_cmd_t;

endpackage

`default_nettype wire

[hdl/ise_ram.sv]
// ----------------------------------------------------------------------------
// ise_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/ise_ctrl.sv]
// ----------------------------------------------------------------------------
// ise_ctrl
// Sequencer: decodes a word, keeps the count, drives the RAM, emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_stack_engine_defines.svh"

module ise_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  input  wire ise_pkg::in_word_t          req,
  output logic                            req_stall,
  input  wire logic                       out_free,
  output ise_pkg::emit_t                  emit,
  output ise_pkg::ram_cmd_t               cmd,
  input  wire logic [ise_pkg::DATA_W-1:0] rdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EMIT = 4'b0100,
    S_DISP = 4'b1000
  } state_t;

  state_t             state, state_next;
  ise_pkg::cnt_t      count, count_next;
  ise_pkg::addr_t     idx, idx_next;
  ise_pkg::out_word_t res, res_next;

  logic           full;
  logic           empty;
  logic           pos_ok;
  ise_pkg::addr_t cnt_a;
  ise_pkg::addr_t top_a;
  ise_pkg::addr_t pos_a;

  assign req_stall = (state != S_IDLE);

  assign full   = (count == ise_pkg::cnt_t'(ise_pkg::DEPTH));
  assign empty  = (count == '0);
  assign pos_ok = (req.position != '0) && (req.position <= ise_pkg::pos_t'(count));
  assign cnt_a  = ise_pkg::addr_t'(count);
  assign top_a  = ise_pkg::addr_t'(count - ise_pkg::cnt_t'(1));
  assign pos_a  = ise_pkg::addr_t'(ise_pkg::pos_t'(count) - req.position);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    res_next   = res;
    cmd        = '0;
    emit       = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.opcode)
            ise_pkg::OP_PUSH: begin
              state_next = S_EMIT;
              if (full) begin
                res_next = '{ise_pkg::ST_OVERFLOW, '0, 1'b1};
              end else begin
                cmd.we     = 1'b1;
                cmd.waddr  = cnt_a;
                cmd.wdata  = req.value;
                count_next = count + ise_pkg::cnt_t'(1);
                res_next   = '{ise_pkg::ST_OK, '0, 1'b1};
              end
            end
            ise_pkg::OP_POP: begin
              if (empty) begin
                res_next   = '{ise_pkg::ST_UNDERFLOW, '0, 1'b1};
                state_next = S_EMIT;
              end else begin
                cmd.re     = 1'b1;
                cmd.raddr  = top_a;
                count_next = count - ise_pkg::cnt_t'(1);
                state_next = S_READ;
              end
            end
            ise_pkg::OP_DISPLAY: begin
              if (empty) begin
                res_next   = '{ise_pkg::ST_EMPTY, '0, 1'b1};
                state_next = S_EMIT;
              end else begin
                cmd.re     = 1'b1;
                cmd.raddr  = top_a;
                idx_next   = top_a;
                state_next = S_DISP;
              end
            end
            ise_pkg::OP_PEEK: begin
              if (!pos_ok) begin
                res_next   = '{ise_pkg::ST_BADPOS, '0, 1'b1};
                state_next = S_EMIT;
              end else begin
                cmd.re     = 1'b1;
                cmd.raddr  = pos_a;
                state_next = S_READ;
              end
            end
            ise_pkg::OP_CHANGE: begin
              state_next = S_EMIT;
              if (!pos_ok) begin
                res_next = '{ise_pkg::ST_BADPOS, '0, 1'b1};
              end else begin
                cmd.we    = 1'b1;
                cmd.waddr = pos_a;
                cmd.wdata = req.value;
                res_next  = '{ise_pkg::ST_OK, '0, 1'b1};
              end
            end
            default: begin
              // unused opcode: drop the word
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          emit       = '{1'b1, '{ise_pkg::ST_OK, $signed(rdata), 1'b1}};
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit       = '{1'b1, res};
          state_next = S_IDLE;
        end
      end
      S_DISP: begin
        // hold the read data until the output register frees up
        if (out_free) begin
          emit = '{1'b1, '{ise_pkg::ST_OK, $signed(rdata), (idx == '0)}};
          if (idx == '0) begin
            state_next = S_IDLE;
          end else begin
            cmd.re    = 1'b1;
            cmd.raddr = idx - ise_pkg::addr_t'(1);
            idx_next  = idx - ise_pkg::addr_t'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    res <= res_next;
  end

  `ISE_ASSERT(a_count_bound, (count <= ise_pkg::cnt_t'(ise_pkg::DEPTH)), "count above depth")
  `ISE_ASSERT(a_emit_free, (emit.valid |-> out_free), "result emitted into a busy output")
  `ISE_ASSERT(a_no_rw_clash, (!(cmd.we && cmd.re)), "RAM read and write in one cycle")
  `ISE_ASSERT(a_last_idle, (emit.valid && emit.word.last |=> state == S_IDLE), "last word not closing the item")
  `ISE_ASSERT(a_ram_idle, (state == S_IDLE && !req_valid |-> !cmd.we && !cmd.re), "RAM access without a word")

endmodule

`default_nettype wire

[hdl/indexed_stack_engine.sv]
// ----------------------------------------------------------------------------
// indexed_stack_engine
// LIFO stack of signed words with push, pop, peek, change and display.
// ----------------------------------------------------------------------------
// Push, pop, peek, change and every error case: one result per word, via
// S_EMIT or S_READ into the output register. Pop and peek read the RAM at
// accept. Display: one RAM read and one result per cycle while the output
// is free. The single output register lets a finished result wait while
// the next word is accepted. Reset clears the count and the sequencer, not RAM.
`timescale 1ns / 1ps
`default_nettype none

module indexed_stack_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire ise_pkg::in_word_t  req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output ise_pkg::out_word_t      rsp
);

  ise_pkg::emit_t                emit;
  ise_pkg::ram_cmd_t             cmd;
  logic [ise_pkg::DATA_W-1:0]    rdata;
  logic                          out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  ise_ram #(
    .WIDTH (ise_pkg::DATA_W),
    .DEPTH (ise_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.waddr),
    .wdata (cmd.wdata),
    .re    (cmd.re),
    .raddr (cmd.raddr),
    .rdata (rdata)
  );

  ise_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .out_free  (out_free),
    .emit      (emit),
    .cmd       (cmd),
    .rdata     (rdata)
  );

  // output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit.valid) begin
      rsp <= emit.word;
    end
  end

endmodule

`default_nettype wire
